FILE: rtl/bsec_pkg.sv
// ----------------------------------------------------------------------------
// bsec_pkg: shared types and constants for the boosted stump classifier
// Table entry layout, item commands, score widths and the control/status
// bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package bsec_pkg;

  localparam int unsigned MaxStumps   = 32;
  localparam int unsigned NumFeatures = 5;
  localparam int unsigned NumClasses  = 3;

  localparam int unsigned IdxW   = $clog2(MaxStumps);
  localparam int unsigned CntW   = IdxW + 1;
  localparam int unsigned FeatW  = 16;
  localparam int unsigned AlphaW = 16;
  localparam int unsigned ScoreW = 21;

  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_BALL = 2'd1,
    CLS_BOX  = 2'd2
  } cls_e;

  localparam logic [2:0] FeatA = 3'd0;
  localparam logic [2:0] FeatB = 3'd1;
  localparam logic [2:0] FeatC = 3'd2;
  localparam logic [2:0] FeatD = 3'd3;
  localparam logic [2:0] FeatE = 3'd4;

  // Register index of stumps_in_use
  localparam logic CfgStumpsInUse = 1'b0;

  typedef struct packed {
    logic [2:0]              feat;
    logic signed [FeatW-1:0] thr;
    logic                    dir;
    logic [1:0]              cls;
    logic [AlphaW-1:0]       alpha;
  } stump_t;

  typedef struct packed {
    logic wr_en;     // write table entry from input
    logic start;     // latch features, clear scores, rewind walk
    logic issue;     // read next table entry
    logic out_load;  // move scores and winner into output register
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/boosted_stump_ensemble_classifier_unit.sv
// ----------------------------------------------------------------------------
// boosted_stump_ensemble_classifier_unit: decision-stump ensemble scorer
// Loads a 32-entry stump table and scores five-feature samples against it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): cmd_i = 0 writes one table
//   entry at entry_index_i and finishes in the accept cycle with no result.
//   cmd_i = 1 classifies feature_a_i..feature_e_i and yields one
//   transaction on the output channel (out_valid_o / out_stall_i).
//   A classification walks the table one entry per cycle through the
//   table's single registered read port, over N = min(stumps_in_use, 32)
//   entries; the input stays stalled from acceptance until the result
//   is moved into the output register. One item is in work at a time;
//   a finished result may wait in the output register while the next
//   item is taken.
//   When the receiver stalls, the result holds in the output register; a
//   following classification waits in its last step until the register
//   frees up, and table loads wait with it; with the sequencer idle, loads go on.
//   Reset clears stumps_in_use, the sequencer and the output valid; table
//   contents are undefined until loaded.
//   Configuration: stumps_in_use at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module boosted_stump_ensemble_classifier_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [4:0]                         entry_index_i,
  input  logic [2:0]                         stump_feature_i,
  input  logic signed [15:0]                 stump_threshold_i,
  input  logic                               stump_direction_i,
  input  logic [1:0]                         stump_class_i,
  input  logic [15:0]                        stump_alpha_i,
  input  logic signed [15:0]                 feature_a_i,
  input  logic signed [15:0]                 feature_b_i,
  input  logic signed [15:0]                 feature_c_i,
  input  logic signed [15:0]                 feature_d_i,
  input  logic signed [15:0]                 feature_e_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         predicted_class_o,
  output logic [20:0]                        score_none_o,
  output logic [20:0]                        score_ball_o,
  output logic [20:0]                        score_box_o
);

  localparam int unsigned CW = bsec_pkg::CntW;

  logic [5:0]          stumps_q;
  logic [CW-1:0]       stumps_sat;
  logic                cfg_wr;
  bsec_pkg::dp_cmd_t   dp_cmd;
  bsec_pkg::dp_stat_t  dp_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stumps_q <= '0;
    end else if (cfg_wr && (paddr[2] == bsec_pkg::CfgStumpsInUse)) begin
      stumps_q <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == bsec_pkg::CfgStumpsInUse) ? {26'd0, stumps_q} : 32'd0;

  // clamp the walk length to the table depth
  assign stumps_sat = (stumps_q > 6'(bsec_pkg::MaxStumps)) ?
                      CW'(bsec_pkg::MaxStumps) : CW'(stumps_q);

  bsec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  bsec_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .stumps_i          (stumps_sat),
    .entry_index_i     (entry_index_i),
    .stump_feature_i   (stump_feature_i),
    .stump_threshold_i (stump_threshold_i),
    .stump_direction_i (stump_direction_i),
    .stump_class_i     (stump_class_i),
    .stump_alpha_i     (stump_alpha_i),
    .feature_a_i       (feature_a_i),
    .feature_b_i       (feature_b_i),
    .feature_c_i       (feature_c_i),
    .feature_d_i       (feature_d_i),
    .feature_e_i       (feature_e_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .predicted_class_o (predicted_class_o),
    .score_none_o      (score_none_o),
    .score_ball_o      (score_ball_o),
    .score_box_o       (score_box_o)
  );

endmodule

FILE: rtl/bsec_ctrl.sv
// ----------------------------------------------------------------------------
// bsec_ctrl: item sequencer
// Accepts one item at a time, steps the table walk of a classification and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module bsec_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 cmd_i,
  output logic                 in_stall_o,
  input  bsec_pkg::dp_stat_t   stat_i,
  output bsec_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == bsec_pkg::CMD_CLASSIFY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_RUN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_RUN: begin
        // the last read accumulates in the cycle the walk reports done
        if (stat_i.walk_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/bsec_dp.sv
// ----------------------------------------------------------------------------
// bsec_dp: stump table, feature latch, score accumulators, output register
// One table entry is read per cycle; its vote is added in the following cycle.
// ----------------------------------------------------------------------------
module bsec_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bsec_pkg::dp_cmd_t                    cmd_i,
  output bsec_pkg::dp_stat_t                   stat_o,
  input  logic [bsec_pkg::CntW-1:0]            stumps_i,
  input  logic [bsec_pkg::IdxW-1:0]            entry_index_i,
  input  logic [2:0]                           stump_feature_i,
  input  logic signed [bsec_pkg::FeatW-1:0]    stump_threshold_i,
  input  logic                                 stump_direction_i,
  input  logic [1:0]                           stump_class_i,
  input  logic [bsec_pkg::AlphaW-1:0]          stump_alpha_i,
  input  logic signed [bsec_pkg::FeatW-1:0]    feature_a_i,
  input  logic signed [bsec_pkg::FeatW-1:0]    feature_b_i,
  input  logic signed [bsec_pkg::FeatW-1:0]    feature_c_i,
  input  logic signed [bsec_pkg::FeatW-1:0]    feature_d_i,
  input  logic signed [bsec_pkg::FeatW-1:0]    feature_e_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           predicted_class_o,
  output logic [bsec_pkg::ScoreW-1:0]          score_none_o,
  output logic [bsec_pkg::ScoreW-1:0]          score_ball_o,
  output logic [bsec_pkg::ScoreW-1:0]          score_box_o
);

  localparam int unsigned SW = bsec_pkg::ScoreW;

  bsec_pkg::stump_t mem [bsec_pkg::MaxStumps];
  bsec_pkg::stump_t rd_data_q, wr_entry;
  logic             rd_vld_q;

  logic [bsec_pkg::CntW-1:0] idx_q;

  logic signed [bsec_pkg::FeatW-1:0] feat_q [bsec_pkg::NumFeatures];
  logic signed [bsec_pkg::FeatW-1:0] x_sel;
  logic                              feat_ok, fire;

  logic [SW-1:0] score_q [bsec_pkg::NumClasses];
  logic [SW:0]   sum;
  logic [SW-1:0] sum_sat;
  logic [SW-1:0] acc_sel;

  logic [1:0]    best;
  logic [SW-1:0] best_score;

  logic          out_vld_q;
  logic [1:0]    out_cls_q;
  logic [SW-1:0] out_s0_q, out_s1_q, out_s2_q;

  assign wr_entry = '{feat: stump_feature_i, thr: stump_threshold_i,
                      dir: stump_direction_i, cls: stump_class_i,
                      alpha: stump_alpha_i};

  // table: one write port, one registered read port, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[entry_index_i] <= wr_entry;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[idx_q[bsec_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign stat_o.walk_done = (idx_q == stumps_i) && !cmd_i.start;
  assign stat_o.out_free  = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      feat_q[0] <= feature_a_i;
      feat_q[1] <= feature_b_i;
      feat_q[2] <= feature_c_i;
      feat_q[3] <= feature_d_i;
      feat_q[4] <= feature_e_i;
    end
  end

  always_comb begin
    x_sel   = '0;
    feat_ok = 1'b1;
    case (rd_data_q.feat)
      bsec_pkg::FeatA: x_sel = feat_q[0];
      bsec_pkg::FeatB: x_sel = feat_q[1];
      bsec_pkg::FeatC: x_sel = feat_q[2];
      bsec_pkg::FeatD: x_sel = feat_q[3];
      bsec_pkg::FeatE: x_sel = feat_q[4];
      default:         feat_ok = 1'b0;
    endcase
  end

  assign fire = feat_ok &&
                (rd_data_q.dir ? (x_sel > rd_data_q.thr) : (x_sel < rd_data_q.thr));

  always_comb begin
    acc_sel = '0;
    case (rd_data_q.cls)
      bsec_pkg::CLS_NONE: acc_sel = score_q[0];
      bsec_pkg::CLS_BALL: acc_sel = score_q[1];
      bsec_pkg::CLS_BOX:  acc_sel = score_q[2];
      default:            acc_sel = '0;
    endcase
  end

  assign sum     = {1'b0, acc_sel} + {{(SW + 1 - bsec_pkg::AlphaW){1'b0}}, rd_data_q.alpha};
  assign sum_sat = sum[SW] ? bsec_pkg::ScoreMax : sum[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      score_q[0] <= '0;
      score_q[1] <= '0;
      score_q[2] <= '0;
    end else if (rd_vld_q && fire) begin
      // a class code beyond the last class drops the vote
      case (rd_data_q.cls)
        bsec_pkg::CLS_NONE: score_q[0] <= sum_sat;
        bsec_pkg::CLS_BALL: score_q[1] <= sum_sat;
        bsec_pkg::CLS_BOX:  score_q[2] <= sum_sat;
        default: ;
      endcase
    end
  end

  // lowest class wins a tie
  always_comb begin
    best       = bsec_pkg::CLS_NONE;
    best_score = score_q[0];
    if (score_q[1] > best_score) begin
      best       = bsec_pkg::CLS_BALL;
      best_score = score_q[1];
    end
    if (score_q[2] > best_score) begin
      best       = bsec_pkg::CLS_BOX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cls_q <= best;
      out_s0_q  <= score_q[0];
      out_s1_q  <= score_q[1];
      out_s2_q  <= score_q[2];
    end
  end

  assign out_valid_o       = out_vld_q;
  assign predicted_class_o = out_cls_q;
  assign score_none_o      = out_s0_q;
  assign score_ball_o      = out_s1_q;
  assign score_box_o       = out_s2_q;

endmodule

FILE: bench/bsec_checker.sv
// ----------------------------------------------------------------------------
// bsec_checker: scoreboard for the boosted stump classifier
// Watches the configuration port and both channels, keeps its own copy of
// the stump table and the stump limit, predicts the class and scores of
// every accepted classification and compares each returned transaction.
// ----------------------------------------------------------------------------
module bsec_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [4:0]          entry_index_i,
  input  logic [2:0]          stump_feature_i,
  input  logic signed [15:0]  stump_threshold_i,
  input  logic                stump_direction_i,
  input  logic [1:0]          stump_class_i,
  input  logic [15:0]         stump_alpha_i,
  input  logic signed [15:0]  feature_a_i,
  input  logic signed [15:0]  feature_b_i,
  input  logic signed [15:0]  feature_c_i,
  input  logic signed [15:0]  feature_d_i,
  input  logic signed [15:0]  feature_e_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [1:0]          predicted_class_o,
  input  logic [20:0]         score_none_o,
  input  logic [20:0]         score_ball_o,
  input  logic [20:0]         score_box_o,
  output int unsigned         mismatch_count_o,
  output int unsigned         awaiting_o
);

  localparam int unsigned SW = bsec_pkg::ScoreW;
  localparam int unsigned FW = bsec_pkg::FeatW;
  localparam int unsigned NF = bsec_pkg::NumFeatures;
  localparam int unsigned NC = bsec_pkg::NumClasses;
  localparam logic [2:0]  LimitAddr = {bsec_pkg::CfgStumpsInUse, 2'b00};

  typedef struct packed {
    logic [1:0]    winner;
    logic [SW-1:0] s_none;
    logic [SW-1:0] s_ball;
    logic [SW-1:0] s_box;
  } tally_t;

  bsec_pkg::stump_t stump_bank [bsec_pkg::MaxStumps];
  logic [5:0]       stump_limit;
  tally_t           pending_tallies [$];

  function automatic tally_t tally_votes(input logic [NF-1:0][FW-1:0] xs);
    logic [NC-1:0][SW:0]  acc;
    int unsigned          span;
    logic [1:0]           best;
    bsec_pkg::stump_t     e;
    logic signed [FW-1:0] x;
    logic                 fire;
    tally_t               r;
    acc  = '0;
    span = (stump_limit > 6'(bsec_pkg::MaxStumps)) ? bsec_pkg::MaxStumps
                                                    : 32'(stump_limit);
    for (int unsigned k = 0; k < span; k++) begin
      e = stump_bank[k[4:0]];
      // out-of-range feature or class: the stump never votes
      if (e.feat < 3'(NF) && e.cls < 2'(NC)) begin
        x    = xs[e.feat];
        fire = e.dir ? (x > $signed(e.thr)) : (x < $signed(e.thr));
        if (fire) begin
          acc[e.cls] = acc[e.cls] + {{(SW + 1 - bsec_pkg::AlphaW){1'b0}}, e.alpha};
          if (acc[e.cls] > {1'b0, bsec_pkg::ScoreMax}) begin
            acc[e.cls] = {1'b0, bsec_pkg::ScoreMax};
          end
        end
      end
    end
    // strict compare keeps the lowest class on ties
    best = bsec_pkg::CLS_NONE;
    for (int unsigned c = 1; c < NC; c++) begin
      if (acc[c[1:0]] > acc[best]) best = c[1:0];
    end
    r.winner = best;
    r.s_none = acc[bsec_pkg::CLS_NONE][SW-1:0];
    r.s_ball = acc[bsec_pkg::CLS_BALL][SW-1:0];
    r.s_box  = acc[bsec_pkg::CLS_BOX][SW-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    tally_t fresh;
    if (!rst_ni) begin
      stump_limit = '0;
      pending_tallies.delete();
      mismatch_count_o = 0;
      awaiting_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LimitAddr) begin
        stump_limit = pwdata[5:0];
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_tallies.size() == 0) begin
          $error("result transaction with no classification outstanding");
          mismatch_count_o++;
        end else begin
          want = pending_tallies.pop_front();
          compare_field("predicted_class", 32'(want.winner), 32'(predicted_class_o));
          compare_field("score_none", 32'(want.s_none), 32'(score_none_o));
          compare_field("score_ball", 32'(want.s_ball), 32'(score_ball_o));
          compare_field("score_box", 32'(want.s_box), 32'(score_box_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (cmd_i == bsec_pkg::CMD_LOAD) begin
          stump_bank[entry_index_i] = {stump_feature_i, stump_threshold_i,
                                       stump_direction_i, stump_class_i, stump_alpha_i};
        end else begin
          fresh = tally_votes({feature_e_i, feature_d_i, feature_c_i,
                               feature_b_i, feature_a_i});
          pending_tallies.insert(pending_tallies.size(), fresh);
        end
      end
      awaiting_o = $unsigned(pending_tallies.size());
    end
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the boosted stump classifier
// Loads stump tables, sets the stump limit through the configuration port
// and sends directed and random classifications with random gaps on the
// input side and random stalls on the result side; bsec_checker scores it.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NF         = bsec_pkg::NumFeatures;
  localparam int unsigned FW         = bsec_pkg::FeatW;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned Settle     = 40;
  localparam int unsigned Phases     = 14;
  localparam int unsigned PhaseItems = 110;
  localparam int unsigned CalmPhase  = 5;
  localparam logic [2:0]  LimitAddr  = {bsec_pkg::CfgStumpsInUse, 2'b00};
  localparam logic [2:0]  FeatNone   = 3'(NF);
  localparam logic [2:0]  FeatTop    = 3'd7;
  localparam logic [1:0]  ClsVoid    = 2'd3;

  localparam int unsigned PhaseLimit [Phases] =
    '{32, 1, 63, 0, 33, 32, 31, 2, 32, 16, 5, 40, 0, 64};

  typedef enum int unsigned {
    TBL_SPREAD = 0,
    TBL_TIES   = 1,
    TBL_PILEUP = 2
  } table_style_e;

  typedef struct packed {
    bsec_pkg::cmd_e        cmd;
    logic [4:0]            idx;
    logic [2:0]            feat;
    logic [15:0]           thr;
    logic                  dir;
    logic [1:0]            cls;
    logic [15:0]           alpha;
    logic [NF-1:0][FW-1:0] xs;
  } item_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               psel              = 1'b0;
  logic               penable           = 1'b0;
  logic               pwrite            = 1'b0;
  logic [2:0]         paddr             = '0;
  logic [31:0]        pwdata            = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic               cmd_i             = 1'b0;
  logic [4:0]         entry_index_i     = '0;
  logic [2:0]         stump_feature_i   = '0;
  logic signed [15:0] stump_threshold_i = '0;
  logic               stump_direction_i = 1'b0;
  logic [1:0]         stump_class_i     = '0;
  logic [15:0]        stump_alpha_i     = '0;
  logic signed [15:0] feature_a_i       = '0;
  logic signed [15:0] feature_b_i       = '0;
  logic signed [15:0] feature_c_i       = '0;
  logic signed [15:0] feature_d_i       = '0;
  logic signed [15:0] feature_e_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [1:0]         predicted_class_o;
  logic [20:0]        score_none_o;
  logic [20:0]        score_ball_o;
  logic [20:0]        score_box_o;

  int unsigned mismatch_count;
  int unsigned awaiting;
  int unsigned cycles       = 0;
  int unsigned n_loads      = 0;
  int unsigned n_classifies = 0;
  int unsigned n_limits     = 0;
  bit          calm         = 1'b0;
  logic [15:0] thr_seen [bsec_pkg::MaxStumps] = '{default: '0};

  boosted_stump_ensemble_classifier_unit u_dut (.*);

  bsec_checker u_checker (
    .*,
    .mismatch_count_o (mismatch_count),
    .awaiting_o       (awaiting)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);
  end

  function automatic item_t noise();
    item_t it;
    it.cmd   = bsec_pkg::cmd_e'($urandom_range(0, 1));
    it.idx   = 5'($urandom_range(0, 31));
    it.feat  = 3'($urandom_range(0, 7));
    it.thr   = 16'($urandom_range(0, 65535));
    it.dir   = 1'($urandom_range(0, 1));
    it.cls   = 2'($urandom_range(0, 3));
    it.alpha = 16'($urandom_range(0, 65535));
    for (int j = 0; j < NF; j++) it.xs[j] = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic logic [NF-1:0][FW-1:0] xs_of(
    input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
    input logic [15:0] d, input logic [15:0] e);
    return {e, d, c, b, a};
  endfunction

  // mix of raw values, values at or next to a loaded threshold, extremes and small values near zero
  function automatic logic [NF-1:0][FW-1:0] sample_for();
    logic [NF-1:0][FW-1:0] xs;
    int unsigned           r;
    for (int j = 0; j < NF; j++) begin
      r = $urandom_range(0, 9);
      if (r < 4)       xs[j] = 16'($urandom_range(0, 65535));
      else if (r < 7)  xs[j] = 16'(thr_seen[5'($urandom_range(0, 31))]
                                   + $urandom_range(0, 2) - 1);
      else if (r == 7) xs[j] = 16'h8000;
      else if (r == 8) xs[j] = 16'h7fff;
      else             xs[j] = 16'($urandom_range(0, 1023) - 512);
    end
    return xs;
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_i             <= it.cmd;
    entry_index_i     <= it.idx;
    stump_feature_i   <= it.feat;
    stump_threshold_i <= it.thr;
    stump_direction_i <= it.dir;
    stump_class_i     <= it.cls;
    stump_alpha_i     <= it.alpha;
    feature_a_i       <= it.xs[0];
    feature_b_i       <= it.xs[1];
    feature_c_i       <= it.xs[2];
    feature_d_i       <= it.xs[3];
    feature_e_i       <= it.xs[4];
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic load_stump(input logic [4:0] idx, input logic [2:0] f,
                            input logic [15:0] t, input logic d,
                            input logic [1:0] c, input logic [15:0] a);
    item_t it;
    it       = noise();
    it.cmd   = bsec_pkg::CMD_LOAD;
    it.idx   = idx;
    it.feat  = f;
    it.thr   = t;
    it.dir   = d;
    it.cls   = c;
    it.alpha = a;
    thr_seen[idx] = t;
    send_item(it);
    n_loads++;
  endtask

  task automatic classify(input logic [NF-1:0][FW-1:0] xs);
    item_t it;
    it     = noise();
    it.cmd = bsec_pkg::CMD_CLASSIFY;
    it.xs  = xs;
    send_item(it);
    n_classifies++;
  endtask

  task automatic load_random_stump(input logic [4:0] idx, input table_style_e style,
                                   input logic [1:0] pile_cls);
    logic [2:0]  f;
    logic [15:0] t;
    logic [1:0]  c;
    logic [15:0] a;
    int unsigned r;
    f = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, NF - 1))
                                   : 3'($urandom_range(NF, 7));
    c = ($urandom_range(0, 9) < 9) ? 2'($urandom_range(0, bsec_pkg::NumClasses - 1))
                                   : ClsVoid;
    r = $urandom_range(0, 9);
    if (r < 6)       t = 16'($urandom_range(0, 65535));
    else if (r == 6) t = 16'h8000;
    else if (r == 7) t = 16'h7fff;
    else             t = 16'($urandom_range(0, 1023) - 512);
    r = $urandom_range(0, 9);
    a = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : 16'($urandom_range(0, 65535));
    case (style)
      TBL_TIES: begin
        a = $urandom_range(0, 1) ? 16'h1000 : 16'h2000;
        t = 16'($urandom_range(0, 1023) - 512);
      end
      TBL_PILEUP: begin
        // every stump votes the same class at full weight unless the feature is minimum
        f = 3'($urandom_range(0, NF - 1));
        t = 16'h8000;
        c = pile_cls;
        a = 16'hffff;
      end
      default: ;
    endcase
    load_stump(idx, f, t, 1'($urandom_range(0, 1)) || style == TBL_PILEUP, c, a);
  endtask

  task automatic write_limit(input logic [5:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= {26'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_limits++;
  endtask

  // drop valid, let outstanding results drain, then cover the longest walk
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  initial begin
    table_style_e style;
    logic [1:0]   pile_cls;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // limit is zero out of reset: empty ensemble, all scores zero
    classify(xs_of(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000));

    load_stump(5'd0, bsec_pkg::FeatA, 16'h0000, 1'b1, bsec_pkg::CLS_NONE, 16'h1000);
    load_stump(5'd1, bsec_pkg::FeatB, 16'h0000, 1'b0, bsec_pkg::CLS_BALL, 16'h1000);
    load_stump(5'd2, bsec_pkg::FeatC, 16'd100,  1'b1, bsec_pkg::CLS_BOX,  16'hffff);
    load_stump(5'd3, bsec_pkg::FeatD, 16'h8000, 1'b0, bsec_pkg::CLS_BOX,  16'hffff);
    load_stump(5'd4, bsec_pkg::FeatE, 16'h7fff, 1'b1, bsec_pkg::CLS_BALL, 16'hffff);
    load_stump(5'd5, FeatNone,        16'h0000, 1'b1, bsec_pkg::CLS_NONE, 16'hffff);
    load_stump(5'd6, FeatTop,         16'h8000, 1'b1, bsec_pkg::CLS_BALL, 16'hffff);
    load_stump(5'd7, bsec_pkg::FeatA, 16'hffff, 1'b1, ClsVoid,            16'hffff);
    wait_drained();
    write_limit(6'd8);

    classify(xs_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    classify(xs_of(16'h0001, 16'hffff, 16'h0000, 16'h0000, 16'h0000));
    classify(xs_of(16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000));
    classify(xs_of(16'h0000, 16'h0000, 16'd101,  16'h0000, 16'h0000));
    classify(xs_of(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    classify(xs_of(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    classify(xs_of(16'h0000, 16'h0000, 16'd100,  16'h0000, 16'h0000));
    wait_drained();
    write_limit(6'd1);
    classify(xs_of(16'h0001, 16'hffff, 16'h7fff, 16'h0000, 16'h0000));

    for (int k = 0; k < bsec_pkg::MaxStumps; k++) begin
      load_random_stump(5'(k), TBL_SPREAD, bsec_pkg::CLS_NONE);
    end

    for (int p = 0; p < Phases; p++) begin
      style    = table_style_e'(p % 3);
      pile_cls = 2'($urandom_range(0, bsec_pkg::NumClasses - 1));
      wait_drained();
      calm = (p == CalmPhase);
      write_limit(PhaseLimit[p] > 63 ? 6'($urandom_range(0, 63)) : 6'(PhaseLimit[p]));
      if (style == TBL_PILEUP) begin
        for (int k = 0; k < bsec_pkg::MaxStumps; k++) begin
          load_random_stump(5'(k), style, pile_cls);
        end
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 9) < 7) classify(sample_for());
        else load_random_stump(5'($urandom_range(0, 31)), style, pile_cls);
      end
    end
    calm = 1'b0;

    wait_drained();
    $display("Covered %0d classifications and %0d table loads under %0d stump limits",
             n_classifies, n_loads, n_limits);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bsec_pkg.sv
rtl/bsec_ctrl.sv
rtl/bsec_dp.sv
rtl/boosted_stump_ensemble_classifier_unit.sv
bench/bsec_checker.sv
bench/tb.sv
